// ===== hw/rtl/pixel_run_to_rectangle_top_macros.svh =====
// assertion macros for the run-to-rectangle block
// no dependencies; the asserting modules need clk_i and rst_ni in scope
`ifndef PIXEL_RUN_TO_RECTANGLE_TOP_MACROS_SVH
`define PIXEL_RUN_TO_RECTANGLE_TOP_MACROS_SVH

// property checked on every rising edge outside reset
`define PRR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define PRR_ASSERT_NEVER(label, cond, msg) \
  `PRR_ASSERT(label, !(cond), msg)

`endif

// ===== hw/rtl/prr_pkg.sv =====
// shared types, constants and register indexes of the run-to-rectangle block
// no dependencies
`timescale 1ns / 1ps

package prr_pkg;

  // coordinate width of column and row
  localparam int CoordBits = 12;
  localparam int PixW      = 8;
  localparam int MapRowsW  = 13;
  localparam int OriginW   = 32;
  localparam int CellW     = 24;
  localparam int CoordOutW = 40;
  localparam int VertexW   = 32;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;

  // signed width of the flipped row, map_rows minus row
  localparam int FlipW = ((CoordBits > MapRowsW) ? CoordBits : MapRowsW) + 2;

  // run queue between the tracker and the geometry pipeline
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  // reset values of the registers
  localparam logic [PixW-1:0]     FreeThrRst  = 8'd254;
  localparam logic [PixW-1:0]     ObstThrRst  = 8'd100;
  localparam logic [MapRowsW-1:0] MapRowsRst  = 13'd4096;
  localparam logic [CellW-1:0]    CellSizeRst = 24'd3277;
  localparam logic [VertexW-1:0]  VertexRst   = 32'd1;

  // vertices per shape
  localparam logic [VertexW-1:0] QuadVerts = 32'd4;
  localparam logic [VertexW-1:0] BoxVerts  = 32'd8;

  typedef enum logic [CfgIdxW-1:0] {
    RegSelectMode = 3'd0,
    RegFreeThr    = 3'd1,
    RegObstThr    = 3'd2,
    RegMapRows    = 3'd3,
    RegOriginX    = 3'd4,
    RegOriginY    = 3'd5,
    RegCellSize   = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    ShapeQuad = 1'b0,
    ShapeBox  = 1'b1
  } shape_e;

  typedef struct packed {
    shape_e                     mode;
    logic [PixW-1:0]            free_thr;
    logic [PixW-1:0]            obst_thr;
    logic [MapRowsW-1:0]        map_rows;
    logic signed [OriginW-1:0]  x_org;
    logic signed [OriginW-1:0]  y_org;
    logic [CellW-1:0]           cell_size;
  } cfg_t;

  // one finished run
  typedef struct packed {
    logic [CoordBits-1:0] start_col;
    logic [CoordBits-1:0] last_col;
    logic [CoordBits-1:0] row;
  } run_t;

  // queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/prr_cfg.sv =====
// configuration register file of the run-to-rectangle block
// depends on prr_pkg
`timescale 1ns / 1ps

module prr_cfg import prr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // decode the register index
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        RegSelectMode: cfg_d.mode      = shape_e'(cfg_data_i[0]);
        RegFreeThr:    cfg_d.free_thr  = cfg_data_i[PixW-1:0];
        RegObstThr:    cfg_d.obst_thr  = cfg_data_i[PixW-1:0];
        RegMapRows:    cfg_d.map_rows  = cfg_data_i[MapRowsW-1:0];
        RegOriginX:    cfg_d.x_org     = $signed(cfg_data_i[OriginW-1:0]);
        RegOriginY:    cfg_d.y_org     = $signed(cfg_data_i[OriginW-1:0]);
        RegCellSize:   cfg_d.cell_size = cfg_data_i[CellW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= ShapeQuad;
      cfg_q.free_thr  <= FreeThrRst;
      cfg_q.obst_thr  <= ObstThrRst;
      cfg_q.map_rows  <= MapRowsRst;
      cfg_q.x_org     <= '0;
      cfg_q.y_org     <= '0;
      cfg_q.cell_size <= CellSizeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/prr_front.sv =====
// run tracker: classifies pixels and queues each finished run
// depends on prr_pkg
`timescale 1ns / 1ps

module prr_front import prr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PixW-1:0]      pixel_value_i,
  input  logic [CoordBits-1:0] column_i,
  input  logic [CoordBits-1:0] row_i,
  input  logic                 row_end_i,
  input  q_status_t            q_status_i,
  output logic                 push_o,
  output run_t                 run_o
);

  logic                 open_q, open_d;
  logic [CoordBits-1:0] start_q, start_d;
  logic [CoordBits-1:0] last_q, last_d;
  logic [CoordBits-1:0] row_q, row_d;
  logic                 accept;
  logic                 hit;
  logic                 emit;

  // hold the stream off while the run queue is full
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  // pixel class in the selected mode
  assign hit = (cfg_i.mode == ShapeBox) ? (pixel_value_i <= cfg_i.obst_thr)
                                        : (pixel_value_i >= cfg_i.free_thr);

  // run bounds including the current pixel
  always_comb begin
    start_d = start_q;
    last_d  = last_q;
    row_d   = row_q;
    if (hit) begin
      if (!open_q) begin
        start_d = column_i;
        row_d   = row_i;
      end
      last_d = column_i;
    end
  end

  // a run closes at a non-qualifying pixel or at the end of the row
  assign emit = (!hit && open_q) || (row_end_i && (open_q || hit));

  always_comb begin
    open_d = open_q;
    if (accept) begin
      if (emit) begin
        open_d = 1'b0;
      end else if (hit) begin
        open_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      start_q <= '0;
      last_q  <= '0;
      row_q   <= '0;
    end else begin
      open_q <= open_d;
      if (accept) begin
        start_q <= start_d;
        last_q  <= last_d;
        row_q   <= row_d;
      end
    end
  end

  // finished run into the queue
  assign push_o          = accept && emit;
  assign run_o.start_col = start_d;
  assign run_o.last_col  = last_d;
  assign run_o.row       = row_d;

endmodule

// ===== hw/rtl/prr_queue.sv =====
// small run queue between the tracker and the geometry pipeline
// depends on prr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "pixel_run_to_rectangle_top_macros.svh"

module prr_queue import prr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  run_t      data_i,
  input  logic      pop_i,
  output run_t      data_o,
  output q_status_t status_o
);

  run_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q, cnt_d;

  // entry store
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign status_o.empty = (cnt_q == '0);

  // queue checks
  `PRR_ASSERT_NEVER(a_q_no_overflow, push_i && status_o.full, "run queue overflow")
  `PRR_ASSERT_NEVER(a_q_no_underflow, pop_i && status_o.empty, "run queue underflow")
  `PRR_ASSERT(a_q_count_bound, cnt_q <= (QPtrW+1)'(QDepth), "run queue count out of range")

endmodule

// ===== hw/rtl/prr_back.sv =====
// geometry pipeline: scales runs to world rectangles and numbers vertices
// depends on prr_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "pixel_run_to_rectangle_top_macros.svh"

module prr_back import prr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfg_t                        cfg_i,
  input  q_status_t                   q_status_i,
  input  run_t                        run_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [CoordOutW-1:0] x_left_o,
  output logic signed [CoordOutW-1:0] x_right_o,
  output logic signed [CoordOutW-1:0] y_low_o,
  output logic signed [CoordOutW-1:0] y_high_o,
  output logic [VertexW-1:0]          vertex_base_o,
  output logic                        shape_kind_o
);

  logic                 s1_v_q, s1_v_d;
  logic                 s2_v_q, s2_v_d;
  logic                 s1_ready, s2_ready;
  logic [VertexW-1:0]   next_vtx_q, next_vtx_d;

  logic [CoordBits:0]            last_p1;
  logic [FlipW-1:0]              flip_lo, flip_hi;
  logic [CoordBits+CellW-1:0]    mul_xl;
  logic [CoordBits+CellW:0]      mul_xr;
  logic signed [FlipW+CellW:0]   mul_yl, mul_yh;

  logic signed [CoordOutW-1:0] p_xl_q, p_xr_q, p_yl_q, p_yh_q;
  logic [VertexW-1:0]          s1_vtx_q;
  shape_e                      s1_kind_q;

  logic signed [CoordOutW-1:0] xl_q, xr_q, yl_q, yh_q;
  logic [VertexW-1:0]          s2_vtx_q;
  shape_e                      s2_kind_q;

  // stage handshakes
  assign s2_ready = !s2_v_q || !out_stall_i;
  assign s1_ready = !s1_v_q || s2_ready;
  assign pop_o    = !q_status_i.empty && s1_ready;
  assign s1_v_d   = s1_ready ? pop_o : s1_v_q;
  assign s2_v_d   = s2_ready ? s1_v_q : s2_v_q;

  // vertex numbering advances with each run taken from the queue
  assign next_vtx_d = pop_o ? next_vtx_q + ((cfg_i.mode == ShapeBox) ? BoxVerts : QuadVerts)
                            : next_vtx_q;

  // cell products, row flipped against the map height
  assign last_p1 = (CoordBits+1)'(run_i.last_col) + 1'b1;
  assign flip_hi = FlipW'(cfg_i.map_rows) - FlipW'(run_i.row);
  assign flip_lo = flip_hi - 1'b1;
  assign mul_xl  = run_i.start_col * cfg_i.cell_size;
  assign mul_xr  = last_p1 * cfg_i.cell_size;
  assign mul_yl  = $signed(flip_lo) * $signed({1'b0, cfg_i.cell_size});
  assign mul_yh  = $signed(flip_hi) * $signed({1'b0, cfg_i.cell_size});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      next_vtx_q <= VertexRst;
    end else begin
      s1_v_q     <= s1_v_d;
      s2_v_q     <= s2_v_d;
      next_vtx_q <= next_vtx_d;
    end
  end

  // stage one: registered products
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_xl_q    <= $signed(CoordOutW'(mul_xl));
      p_xr_q    <= $signed(CoordOutW'(mul_xr));
      p_yl_q    <= CoordOutW'(mul_yl);
      p_yh_q    <= CoordOutW'(mul_yh);
      s1_vtx_q  <= next_vtx_q;
      s1_kind_q <= cfg_i.mode;
    end
  end

  // stage two: origin offset, output register
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      xl_q      <= CoordOutW'(cfg_i.x_org) + p_xl_q;
      xr_q      <= CoordOutW'(cfg_i.x_org) + p_xr_q;
      yl_q      <= CoordOutW'(cfg_i.y_org) + p_yl_q;
      yh_q      <= CoordOutW'(cfg_i.y_org) + p_yh_q;
      s2_vtx_q  <= s1_vtx_q;
      s2_kind_q <= s1_kind_q;
    end
  end

  assign out_valid_o   = s2_v_q;
  assign x_left_o      = xl_q;
  assign x_right_o     = xr_q;
  assign y_low_o       = yl_q;
  assign y_high_o      = yh_q;
  assign vertex_base_o = s2_vtx_q;
  assign shape_kind_o  = s2_kind_q;

  // pipeline checks
  `PRR_ASSERT(a_vtx_step, pop_o |=> ((next_vtx_q - $past(next_vtx_q)) == QuadVerts) || ((next_vtx_q - $past(next_vtx_q)) == BoxVerts), "vertex number step is neither quad nor box")
  `PRR_ASSERT(a_s2_from_s1, $rose(s2_v_q) |-> $past(s1_v_q), "output valid without a run in stage one")
  `PRR_ASSERT(a_s1_held, (s1_v_q && !s2_ready) |=> s1_v_q, "stage one dropped a run while blocked")

endmodule

// ===== hw/rtl/pixel_run_to_rectangle_top.sv =====
// top level of the run-to-rectangle block
// depends on prr_pkg, prr_cfg, prr_front, prr_queue and prr_back
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// cfg       in         cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
// pixel     in         in_valid_i / in_stall_o       pixel_value_i, column_i, row_i, row_end_i
// rect      out        out_valid_o / out_stall_i     x_left_o .. shape_kind_o
//
// one pixel per cycle while in_stall_o is low; the run tracker updates its state with each accepted pixel
// after the edge that takes the closing pixel, a rectangle passes through the
// queue entry, the product stage and the output register; one rectangle per cycle while out_stall_i is low
// in_stall_o is high only while the four-entry run queue is full
// reset clears the open run, the queue, the pipeline and restarts vertices at 1

module pixel_run_to_rectangle_top import prr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [PixW-1:0]             pixel_value_i,
  input  logic [CoordBits-1:0]        column_i,
  input  logic [CoordBits-1:0]        row_i,
  input  logic                        row_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [CoordOutW-1:0] x_left_o,
  output logic signed [CoordOutW-1:0] x_right_o,
  output logic signed [CoordOutW-1:0] y_low_o,
  output logic signed [CoordOutW-1:0] y_high_o,
  output logic [VertexW-1:0]          vertex_base_o,
  output logic                        shape_kind_o
);

  cfg_t      cfg;
  q_status_t q_status;
  logic      push, pop;
  run_t      run_in, run_out;

  // register file
  prr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // run tracker
  prr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .row_end_i     (row_end_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .run_o         (run_in)
  );

  // run queue
  prr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (run_in),
    .pop_i    (pop),
    .data_o   (run_out),
    .status_o (q_status)
  );

  // geometry pipeline
  prr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_status_i    (q_status),
    .run_i         (run_out),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .x_left_o      (x_left_o),
    .x_right_o     (x_right_o),
    .y_low_o       (y_low_o),
    .y_high_o      (y_high_o),
    .vertex_base_o (vertex_base_o),
    .shape_kind_o  (shape_kind_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the run-to-rectangle block: pixel rows in, rectangles out
// depends on prr_pkg and pixel_run_to_rectangle_top; holds its own run tracker model
`timescale 1ns / 1ps

import prr_pkg::*;

// one expected or observed rectangle
typedef struct packed {
  logic [CoordOutW-1:0] x_left;
  logic [CoordOutW-1:0] x_right;
  logic [CoordOutW-1:0] y_low;
  logic [CoordOutW-1:0] y_high;
  logic [VertexW-1:0]   vertex_base;
  shape_e               kind;
} rect_t;

// run tracker: mirrors the register file, follows the open run and queues rectangles
class rect_tracker;
  shape_e                    mode;
  logic [PixW-1:0]           free_thr;
  logic [PixW-1:0]           obst_thr;
  logic [MapRowsW-1:0]       map_rows;
  logic signed [OriginW-1:0] org_x;
  logic signed [OriginW-1:0] org_y;
  logic [CellW-1:0]          cell_q16;

  bit                        run_open;
  logic [CoordBits-1:0]      run_first;
  logic [CoordBits-1:0]      run_last;
  logic [CoordBits-1:0]      run_row;
  logic [VertexW-1:0]        next_vertex;

  rect_t                     pending_rects[$];
  int                        errors;
  int                        n_rects;

  function new();
    mode        = ShapeQuad;
    free_thr    = FreeThrRst;
    obst_thr    = ObstThrRst;
    map_rows    = MapRowsRst;
    org_x       = '0;
    org_y       = '0;
    cell_q16    = CellSizeRst;
    run_open    = 1'b0;
    run_first   = '0;
    run_last    = '0;
    run_row     = '0;
    next_vertex = VertexRst;
    errors      = 0;
    n_rects     = 0;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    case (idx)
      RegSelectMode: mode     = shape_e'(val[0]);
      RegFreeThr:    free_thr = val[PixW-1:0];
      RegObstThr:    obst_thr = val[PixW-1:0];
      RegMapRows:    map_rows = val[MapRowsW-1:0];
      RegOriginX:    org_x    = val;
      RegOriginY:    org_y    = val;
      RegCellSize:   cell_q16 = val[CellW-1:0];
      default: ;
    endcase
  endfunction

  // finished run to world rectangle, geometry taken from the current registers
  function void close_run();
    longint step, flip, ox, oy, c_first, c_last, xl, xr, yl, yh;
    rect_t  r;
    step    = longint'(cell_q16);
    ox      = longint'(org_x);
    oy      = longint'(org_y);
    c_first = longint'(run_first);
    c_last  = longint'(run_last);
    flip    = longint'(map_rows);
    flip    = flip - longint'(run_row) - 1;
    xl      = ox + c_first * step;
    xr      = ox + (c_last + 1) * step;
    yl      = oy + flip * step;
    yh      = yl + step;
    r.x_left      = xl[CoordOutW-1:0];
    r.x_right     = xr[CoordOutW-1:0];
    r.y_low       = yl[CoordOutW-1:0];
    r.y_high      = yh[CoordOutW-1:0];
    r.vertex_base = next_vertex;
    r.kind        = mode;
    pending_rects.insert(pending_rects.size(), r);
    next_vertex = next_vertex + ((mode == ShapeBox) ? BoxVerts : QuadVerts);
    run_open    = 1'b0;
  endfunction

  // one accepted pixel: qualify, extend or open the run, close it where due
  function void note_pixel(logic [PixW-1:0] pix, logic [CoordBits-1:0] col,
                           logic [CoordBits-1:0] row, bit row_last);
    bit hit;
    hit = (mode == ShapeBox) ? (pix <= obst_thr) : (pix >= free_thr);
    if (hit) begin
      if (!run_open) begin
        run_first = col;
        run_row   = row;
        run_open  = 1'b1;
      end
      run_last = col;
    end else if (run_open) begin
      close_run();
      return;
    end
    if (row_last && run_open) close_run();
  endfunction

  task report(string what);
    errors++;
    $display("mismatch %0d: %s", errors, what);
  endtask

  task cmp_field(string name, logic [CoordOutW-1:0] got, logic [CoordOutW-1:0] want);
    if (got !== want) report($sformatf("rect %0d %s got %h want %h", n_rects, name, got, want));
  endtask

  task check_rect(rect_t got);
    rect_t want;
    if (pending_rects.size() == 0) begin
      report($sformatf("rect %0d arrived with nothing expected", n_rects));
    end else begin
      want = pending_rects.pop_front();
      cmp_field("x_left", got.x_left, want.x_left);
      cmp_field("x_right", got.x_right, want.x_right);
      cmp_field("y_low", got.y_low, want.y_low);
      cmp_field("y_high", got.y_high, want.y_high);
      cmp_field("vertex_base", CoordOutW'(got.vertex_base), CoordOutW'(want.vertex_base));
      cmp_field("shape_kind", CoordOutW'(got.kind), CoordOutW'(want.kind));
    end
    n_rects++;
  endtask
endclass

module tb_top;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        cfg_valid_i   = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIdxW-1:0]          cfg_index_i   = '0;
  logic [CfgDataW-1:0]         cfg_data_i    = '0;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic [PixW-1:0]             pixel_value_i = '0;
  logic [CoordBits-1:0]        column_i      = '0;
  logic [CoordBits-1:0]        row_i         = '0;
  logic                        row_end_i     = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic signed [CoordOutW-1:0] x_left_o;
  logic signed [CoordOutW-1:0] x_right_o;
  logic signed [CoordOutW-1:0] y_low_o;
  logic signed [CoordOutW-1:0] y_high_o;
  logic [VertexW-1:0]          vertex_base_o;
  logic                        shape_kind_o;

  rect_tracker sb;
  bit          idle_en = 1'b1;
  int          stall_left = 0;
  int          n_pixels = 0;
  int          n_writes = 0;
  int          drain_cnt;
  rect_t       seen;

  pixel_run_to_rectangle_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_value_i (pixel_value_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .row_end_i     (row_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .x_left_o      (x_left_o),
    .x_right_o     (x_right_o),
    .y_low_o       (y_low_o),
    .y_high_o      (y_high_o),
    .vertex_base_o (vertex_base_o),
    .shape_kind_o  (shape_kind_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // rectangle side: check accepted items, stall in short random bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.x_left      = x_left_o;
        seen.x_right     = x_right_o;
        seen.y_low       = y_low_o;
        seen.y_high      = y_high_o;
        seen.vertex_base = vertex_base_o;
        seen.kind        = shape_e'(shape_kind_o);
        sb.check_rect(seen);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // one pixel item, with an optional gap first; valid stays high afterwards
  task automatic push_pixel(logic [PixW-1:0] pix, logic [CoordBits-1:0] col,
                            logic [CoordBits-1:0] row, bit row_last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    column_i      <= col;
    row_i         <= row;
    row_end_i     <= row_last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(pix, col, row, row_last);
    n_pixels++;
  endtask

  // stop the pixel stream and let every outstanding rectangle drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_rects.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    n_writes++;
  endtask

  // full register load, done only while idle
  task automatic load_config(shape_e mode, logic [PixW-1:0] free_thr,
                             logic [PixW-1:0] obst_thr, logic [MapRowsW-1:0] rows,
                             logic [OriginW-1:0] ox, logic [OriginW-1:0] oy,
                             logic [CellW-1:0] cell_q16);
    reg_write(RegSelectMode, {31'd0, mode});
    reg_write(RegFreeThr, {24'd0, free_thr});
    reg_write(RegObstThr, {24'd0, obst_thr});
    reg_write(RegMapRows, {19'd0, rows});
    reg_write(RegOriginX, ox);
    reg_write(RegOriginY, oy);
    reg_write(RegCellSize, {8'd0, cell_q16});
    cfg_valid_i <= 1'b0;
  endtask

  // grey level that does or does not qualify under the present mode
  function automatic logic [PixW-1:0] pick_pixel(bit want_hit);
    if (sb.mode == ShapeBox) begin
      if (want_hit) return PixW'($urandom_range(0, sb.obst_thr));
      if (sb.obst_thr != 8'd255) return PixW'($urandom_range(sb.obst_thr + 1, 255));
    end else begin
      if (want_hit) return PixW'($urandom_range(sb.free_thr, 255));
      if (sb.free_thr != 8'd0) return PixW'($urandom_range(0, sb.free_thr - 1));
    end
    return PixW'($urandom_range(0, 255));
  endfunction

  // mostly proper rows with mixed runs; some rows lose their row end, some noise
  task automatic run_random(int n_items);
    int                   sent;
    int                   width;
    int                   first;
    int                   k;
    bit                   drop_end;
    logic [CoordBits-1:0] row_no;
    sent   = 0;
    row_no = CoordBits'($urandom_range(0, 4095));
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        push_pixel(PixW'($urandom_range(0, 255)), CoordBits'($urandom_range(0, 4095)),
                   CoordBits'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        width    = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 12);
        first    = ($urandom_range(0, 7) == 0) ? 4096 - width : $urandom_range(0, 4096 - width);
        drop_end = ($urandom_range(0, 9) == 0);
        for (k = 0; k < width; k++) begin
          push_pixel(pick_pixel($urandom_range(0, 9) < 7), CoordBits'(first + k), row_no,
                     (k == width - 1) && !drop_end);
          sent++;
        end
        row_no++;
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    int ph;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: threshold edges, single-pixel run at the far corner,
    // row end on a failing pixel, run carried across rows with columns going back
    push_pixel(8'd255, 12'd0, 12'd0, 1'b0);
    push_pixel(8'd254, 12'd1, 12'd0, 1'b0);
    push_pixel(8'd253, 12'd2, 12'd0, 1'b0);
    push_pixel(8'd255, 12'd4095, 12'd4095, 1'b1);
    push_pixel(8'd0, 12'd0, 12'd1, 1'b1);
    push_pixel(8'd255, 12'd10, 12'd2, 1'b0);
    push_pixel(8'd0, 12'd11, 12'd2, 1'b1);
    push_pixel(8'd255, 12'd4094, 12'd3, 1'b0);
    push_pixel(8'd255, 12'd0, 12'd4, 1'b0);
    push_pixel(8'd255, 12'd5, 12'd4, 1'b1);

    // boxes with extreme geometry, rows beyond the map height, run left open
    settle();
    load_config(ShapeBox, 8'd255, 8'd0, 13'd1, 32'h8000_0000, 32'h7fff_ffff, 24'hff_ffff);
    push_pixel(8'd0, 12'd0, 12'd0, 1'b1);
    push_pixel(8'd0, 12'd4095, 12'd4095, 1'b1);
    push_pixel(8'd1, 12'd5, 12'd5, 1'b1);
    push_pixel(8'd0, 12'd100, 12'd6, 1'b0);

    // mode and geometry change under the open run, zero cell size
    settle();
    load_config(ShapeQuad, 8'd0, 8'd255, 13'd4096, 32'h7fff_ffff, 32'h8000_0000, 24'd0);
    push_pixel(8'd200, 12'd101, 12'd6, 1'b1);
    push_pixel(8'd0, 12'd3, 12'd7, 1'b1);

    // random phases, the last one without any idling
    for (ph = 0; ph < 6; ph++) begin
      settle();
      load_config(shape_e'($urandom_range(0, 1)), PixW'($urandom_range(0, 255)),
                  PixW'($urandom_range(0, 255)),
                  MapRowsW'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 16)
                                                        : $urandom_range(1, 4096)),
                  $urandom, $urandom,
                  CellW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hff_ffff)
                                                     : $urandom_range(1, 262144)));
      idle_en = (ph != 5) && ($urandom_range(0, 3) != 0);
      run_random(200);
    end

    // drain and close
    in_valid_i <= 1'b0;
    drain_cnt = 0;
    while (sb.pending_rects.size() != 0 && drain_cnt < 2000) begin
      @(posedge clk_i);
      drain_cnt++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending_rects.size() != 0)
      sb.report($sformatf("%0d expected rectangles never arrived", sb.pending_rects.size()));

    $display("run covered %0d pixels, %0d rectangles and %0d register writes",
             n_pixels, sb.n_rects, n_writes);
    $display("both modes, threshold and geometry extremes, broken rows and noise included");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/prr_pkg.sv
hw/rtl/prr_cfg.sv
hw/rtl/prr_front.sv
hw/rtl/prr_queue.sv
hw/rtl/prr_back.sv
hw/rtl/pixel_run_to_rectangle_top.sv
tb/tb_top.sv
